### rtl/asmon_pkg.sv
// Shared types, defaults and state codes for the allocation statistics monitor.
package asmon_pkg;

   // Default configuration
   localparam int DEF_BUCKETS     = 16;
   localparam int DEF_BYTE_WIDTH  = 48;
   localparam int DEF_COUNT_WIDTH = 32;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } ctrl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic lookup;
      logic update;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_full;
   } ctrl_status_type;

endpackage

### rtl/asmon_ram.sv
// Generic single-write, single-read RAM with registered read data.
module asmon_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/asmon_ctrl.sv
// Controller state machine: sequences accept, bucket lookup and statistics update.
module asmon_ctrl
   import asmon_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output ctrl_cmd_type    cmd,
   input  ctrl_status_type status
);

   ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!status.out_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_stall  = 1'b1;
      cmd.accept = 1'b0;
      cmd.lookup = 1'b0;
      cmd.update = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = !status.out_full;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

### rtl/asmon_dpath.sv
// Datapath: statistics registers, bucket encoder, histogram RAM and result register.
module asmon_dpath
   import asmon_pkg::*;
#(
   parameter int BUCKETS     = DEF_BUCKETS,
   parameter int BYTE_WIDTH  = DEF_BYTE_WIDTH,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
   parameter int BIDX_W      = $clog2(BUCKETS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ctrl_cmd_type                 cmd,
   output ctrl_status_type              status,
   input  logic signed [BYTE_WIDTH-1:0] req_delta_bytes,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [BYTE_WIDTH-1:0] rsp_live_total,
   output logic [BYTE_WIDTH-2:0]        rsp_peak_total,
   output logic [COUNT_WIDTH-1:0]       rsp_alloc_count,
   output logic [COUNT_WIDTH-1:0]       rsp_free_count,
   output logic [BYTE_WIDTH-2:0]        rsp_largest_size,
   output logic [BIDX_W-1:0]            rsp_bucket_index,
   output logic [COUNT_WIDTH-1:0]       rsp_bucket_count,
   output logic                         rsp_was_alloc
);

   localparam int MSB_W = $clog2(BYTE_WIDTH);
   localparam logic [BYTE_WIDTH-1:0] MAX_LIVE = {1'b0, {(BYTE_WIDTH-1){1'b1}}};
   localparam logic [BYTE_WIDTH-1:0] MIN_LIVE = {1'b1, {(BYTE_WIDTH-1){1'b0}}};

   // Statistics state
   logic [BYTE_WIDTH-1:0]  delta_ff;
   logic [BYTE_WIDTH-1:0]  live_ff, live_in;
   logic [BYTE_WIDTH-2:0]  peak_ff, peak_in;
   logic [COUNT_WIDTH-1:0] alloc_ff, alloc_in;
   logic [COUNT_WIDTH-1:0] free_ff, free_in;
   logic [BYTE_WIDTH-2:0]  largest_ff, largest_in;
   logic [BIDX_W-1:0]      bucket_ff, bucket_in;
   logic [BUCKETS-1:0]     hist_valid_ff, hist_valid_in;

   // Result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [BYTE_WIDTH-1:0]       out_live_ff;
   logic [BYTE_WIDTH-2:0]       out_peak_ff;
   logic [COUNT_WIDTH-1:0]      out_alloc_ff;
   logic [COUNT_WIDTH-1:0]      out_free_ff;
   logic [BYTE_WIDTH-2:0]       out_largest_ff;
   logic [BIDX_W-1:0]           out_bidx_ff;
   logic [COUNT_WIDTH-1:0]      out_bcnt_ff;
   logic                        out_was_ff;

   logic                   is_pos, is_neg;
   logic [BYTE_WIDTH-2:0]  size;
   logic [MSB_W-1:0]       msb;
   logic [BYTE_WIDTH:0]    live_sum;
   logic [COUNT_WIDTH-1:0] ram_rd_data, cur_cnt, new_cnt;

   assign is_neg = delta_ff[BYTE_WIDTH-1];
   assign is_pos = !delta_ff[BYTE_WIDTH-1] && (|delta_ff);
   assign size   = delta_ff[BYTE_WIDTH-2:0];

   // Find the top set bit of the size and clamp it to the last bucket
   always_comb begin
      msb = '0;
      for (int i = 0; i < BYTE_WIDTH - 1; i++) begin
         if (size[i]) begin
            msb = MSB_W'(i);
         end
      end
      if (int'(msb) >= BUCKETS - 1) begin
         bucket_in = BIDX_W'(BUCKETS - 1);
      end else begin
         bucket_in = BIDX_W'(msb);
      end
   end

   // Saturating live total, one bit wider to catch overflow
   always_comb begin
      live_sum = {live_ff[BYTE_WIDTH-1], live_ff} + {delta_ff[BYTE_WIDTH-1], delta_ff};
      if (live_sum[BYTE_WIDTH] != live_sum[BYTE_WIDTH-1]) begin
         live_in = live_sum[BYTE_WIDTH] ? MIN_LIVE : MAX_LIVE;
      end else begin
         live_in = live_sum[BYTE_WIDTH-1:0];
      end
   end

   // Histogram count: an unwritten bucket reads as zero
   assign cur_cnt = hist_valid_ff[bucket_ff] ? ram_rd_data : '0;
   assign new_cnt = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;

   // Next statistics on update
   always_comb begin
      peak_in       = peak_ff;
      alloc_in      = alloc_ff;
      free_in       = free_ff;
      largest_in    = largest_ff;
      hist_valid_in = hist_valid_ff;
      if (!live_ff[BYTE_WIDTH-1] && (live_ff[BYTE_WIDTH-2:0] > peak_ff)) begin
         peak_in = live_ff[BYTE_WIDTH-2:0];
      end
      if (is_pos) begin
         alloc_in = (&alloc_ff) ? alloc_ff : alloc_ff + 1'b1;
         hist_valid_in[bucket_ff] = 1'b1;
         if (size > largest_ff) begin
            largest_in = size;
         end
      end
      if (is_neg) begin
         free_in = (&free_ff) ? free_ff : free_ff + 1'b1;
      end
   end

   // Histogram storage
   asmon_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (BUCKETS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.update && is_pos),
      .wr_addr ($clog2(BUCKETS)'(bucket_ff)),
      .wr_data (new_cnt),
      .rd_en   (cmd.lookup),
      .rd_addr ($clog2(BUCKETS)'(bucket_in)),
      .rd_data (ram_rd_data)
   );

   // Hold the accepted beat; compute bucket and live total on lookup
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         delta_ff <= req_delta_bytes;
      end
      if (cmd.lookup) begin
         bucket_ff <= bucket_in;
      end
   end

   // Statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff       <= '0;
         peak_ff       <= '0;
         alloc_ff      <= '0;
         free_ff       <= '0;
         largest_ff    <= '0;
         hist_valid_ff <= '0;
      end else begin
         if (cmd.lookup) begin
            live_ff <= live_in;
         end
         if (cmd.update) begin
            peak_ff       <= peak_in;
            alloc_ff      <= alloc_in;
            free_ff       <= free_in;
            largest_ff    <= largest_in;
            hist_valid_ff <= hist_valid_in;
         end
      end
   end

   // Result valid: set on update, drop when the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         out_live_ff    <= live_ff;
         out_peak_ff    <= peak_in;
         out_alloc_ff   <= alloc_in;
         out_free_ff    <= free_in;
         out_largest_ff <= largest_in;
         out_bidx_ff    <= is_pos ? bucket_ff : '0;
         out_bcnt_ff    <= is_pos ? new_cnt : '0;
         out_was_ff     <= is_pos;
      end
   end

   assign status.out_full  = rsp_valid_ff && rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_live_total   = out_live_ff;
   assign rsp_peak_total   = out_peak_ff;
   assign rsp_alloc_count  = out_alloc_ff;
   assign rsp_free_count   = out_free_ff;
   assign rsp_largest_size = out_largest_ff;
   assign rsp_bucket_index = out_bidx_ff;
   assign rsp_bucket_count = out_bcnt_ff;
   assign rsp_was_alloc    = out_was_ff;

endmodule

### rtl/allocation_statistics_monitor.sv
// Each beat passes the accept, lookup and update steps in order around the registered
//   histogram RAM read; update waits while a stalled result holds the output, and a new
//   beat is taken only once the last one has left the update step.
// A new beat is accepted while a finished result still waits on the output.
// Reset: synchronous; clears all statistics and marks every histogram bucket
//   empty at once, so the block accepts beats the cycle after reset.
module allocation_statistics_monitor
   import asmon_pkg::*;
#(
   parameter int BUCKETS     = DEF_BUCKETS,
   parameter int BYTE_WIDTH  = DEF_BYTE_WIDTH,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [BYTE_WIDTH-1:0]   req_delta_bytes,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [BYTE_WIDTH-1:0]   rsp_live_total,
   output logic [BYTE_WIDTH-2:0]          rsp_peak_total,
   output logic [COUNT_WIDTH-1:0]         rsp_alloc_count,
   output logic [COUNT_WIDTH-1:0]         rsp_free_count,
   output logic [BYTE_WIDTH-2:0]          rsp_largest_size,
   output logic [$clog2(BUCKETS)-1:0]     rsp_bucket_index,
   output logic [COUNT_WIDTH-1:0]         rsp_bucket_count,
   output logic                           rsp_was_alloc
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Sequencer
   asmon_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Statistics datapath
   asmon_dpath #(
      .BUCKETS     (BUCKETS),
      .BYTE_WIDTH  (BYTE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH),
      .BIDX_W      ($clog2(BUCKETS))
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_delta_bytes  (req_delta_bytes),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_live_total   (rsp_live_total),
      .rsp_peak_total   (rsp_peak_total),
      .rsp_alloc_count  (rsp_alloc_count),
      .rsp_free_count   (rsp_free_count),
      .rsp_largest_size (rsp_largest_size),
      .rsp_bucket_index (rsp_bucket_index),
      .rsp_bucket_count (rsp_bucket_count),
      .rsp_was_alloc    (rsp_was_alloc)
   );

endmodule

### rtl/asmon_checker.sv
// Port-level checks for the allocation statistics monitor, bound to the top level.
module asmon_checker
   import asmon_pkg::*;
#(
   parameter int BUCKETS     = DEF_BUCKETS,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [$clog2(BUCKETS)-1:0]   rsp_bucket_index,
   input logic [COUNT_WIDTH-1:0]       rsp_bucket_count,
   input logic                         rsp_was_alloc
);

   // No result straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // Accepting a beat closes the input until the item is processed
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second beat accepted while busy");

   // An allocation always leaves a nonzero bucket count
   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_alloc |-> rsp_bucket_count != '0)
      else $error("allocation with empty bucket count");

   // Bucket fields are zero when the event was not an allocation
   a_no_alloc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_alloc |-> rsp_bucket_index == '0 && rsp_bucket_count == '0)
      else $error("bucket fields set on a non-allocation");

endmodule

bind allocation_statistics_monitor asmon_checker #(
   .BUCKETS     (BUCKETS),
   .COUNT_WIDTH (COUNT_WIDTH)
) u_asmon_checker (.*);
